// File: hw/rtl/assert_macros.svh
// Assertion macros used by the top RTL file of the box suppression block.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check a property on every clock edge outside reset.
`define GBN_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (prop)) \
    else $error(msg);

// Check that a condition implies a consequence in the same cycle.
`define GBN_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/gbn_pkg.sv
// Types, constants and control structs of the greedy box suppression block.
package gbn_pkg;

  localparam int MaxBoxesDef = 64;
  localparam int InDataW     = 80;
  localparam int OutDataW    = 88;
  localparam int OutUserW    = 2;
  localparam int CfgIdxW     = 1;
  localparam int CfgDataW    = 16;
  localparam int KeptW       = 7;
  localparam int KeptIdxW    = 6;

  localparam logic [KeptW-1:0] KeepCap   = 7'd64;
  localparam logic [15:0]      IouThrRst = 16'd29491;
  localparam logic [KeptW-1:0] MaxDetRst = 7'd64;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_IOU_THR = 1'b0,
    CFG_MAX_DET = 1'b1
  } cfg_idx_e;

  // One box, left edge in the lowest bits.
  typedef struct packed {
    logic [15:0]        score;
    logic [14:0]        height;
    logic [14:0]        width;
    logic signed [15:0] top;
    logic signed [15:0] left;
  } box_t;

  localparam int BoxW = $bits(box_t);

  typedef enum logic [2:0] {
    ST_LOAD,
    ST_SCAN,
    ST_DECIDE,
    ST_EMIT_MID,
    ST_EMIT_LAST,
    ST_EMIT_NONE
  } gbn_state_e;

  typedef struct packed {
    logic load;        // store the accepted box if the store has room
    logic set_start;   // first pass of a new set
    logic pass_start;  // restart the scan for another pass
    logic issue;       // read the next stored box
    logic take_pick;   // best survivor becomes the kept box
    logic emit;        // load the output register
    logic emit_last;   // output is the final result of the set
    logic emit_none;   // output is the nothing-kept marker
    logic clr_set;     // clear box count and overflow
  } gbn_cmd_t;

  typedef struct packed {
    logic issue_avail;
    logic pipe_empty;
    logic best_found;
    logic have_pick;
    logic at_limit;
    logic out_busy;
  } gbn_sts_t;

endpackage

// File: hw/rtl/gbn_ram.sv
// Generic single-write, single-read RAM with registered read data.
module gbn_ram #(
  parameter int Width = 8,
  parameter int Depth = 16,
  localparam int AddrW = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// File: hw/rtl/gbn_ctrl.sv
// Controller state machine: load, scan passes, result sequencing.
module gbn_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_tvalid_i,
  input  logic              in_tlast_i,
  output logic              in_tready_o,
  input  gbn_pkg::gbn_sts_t sts_i,
  output gbn_pkg::gbn_cmd_t cmd_o
);
  import gbn_pkg::*;

  gbn_state_e state_q, state_d;

  // Hold state
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_LOAD;
    end else begin
      state_q <= state_d;
    end
  end

  // Next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_LOAD: begin
        if (in_tvalid_i && in_tlast_i) state_d = ST_SCAN;
      end
      ST_SCAN: begin
        if (!sts_i.issue_avail && sts_i.pipe_empty) state_d = ST_DECIDE;
      end
      ST_DECIDE: begin
        if (!sts_i.best_found) begin
          state_d = sts_i.have_pick ? ST_EMIT_LAST : ST_EMIT_NONE;
        end else if (!sts_i.have_pick) begin
          state_d = sts_i.at_limit ? ST_EMIT_LAST : ST_SCAN;
        end else begin
          state_d = ST_EMIT_MID;
        end
      end
      ST_EMIT_MID: begin
        if (!sts_i.out_busy) state_d = sts_i.at_limit ? ST_EMIT_LAST : ST_SCAN;
      end
      ST_EMIT_LAST, ST_EMIT_NONE: begin
        if (!sts_i.out_busy) state_d = ST_LOAD;
      end
      default: state_d = ST_LOAD;
    endcase
  end

  // Commands
  always_comb begin
    cmd_o       = '0;
    in_tready_o = 1'b0;
    case (state_q)
      ST_LOAD: begin
        in_tready_o     = 1'b1;
        cmd_o.load      = in_tvalid_i;
        cmd_o.set_start = in_tvalid_i && in_tlast_i;
      end
      ST_SCAN: begin
        cmd_o.issue = sts_i.issue_avail;
      end
      ST_DECIDE: begin
        if (sts_i.best_found && !sts_i.have_pick) begin
          cmd_o.take_pick  = 1'b1;
          cmd_o.pass_start = !sts_i.at_limit;
        end
      end
      ST_EMIT_MID: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit       = 1'b1;
          cmd_o.take_pick  = 1'b1;
          cmd_o.pass_start = !sts_i.at_limit;
        end
      end
      ST_EMIT_LAST: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_last = 1'b1;
          cmd_o.clr_set   = 1'b1;
        end
      end
      ST_EMIT_NONE: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.emit_none = 1'b1;
          cmd_o.clr_set   = 1'b1;
        end
      end
      default: cmd_o = '0;
    endcase
  end

endmodule

// File: hw/rtl/gbn_datapath.sv
// Datapath: box stores, IoU pipeline, best-survivor tracking, output register.
module gbn_datapath #(
  parameter int MAX_BOXES = gbn_pkg::MaxBoxesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  gbn_pkg::gbn_cmd_t             cmd_i,
  output gbn_pkg::gbn_sts_t             sts_o,
  input  logic [gbn_pkg::InDataW-1:0]   in_data_i,
  input  logic                          cfg_valid_i,
  input  logic [gbn_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gbn_pkg::CfgDataW-1:0]  cfg_data_i,
  output logic                          out_tvalid_o,
  input  logic                          out_tready_i,
  output logic [gbn_pkg::OutDataW-1:0]  out_tdata_o,
  output logic [gbn_pkg::OutUserW-1:0]  out_tuser_o,
  output logic                          out_tlast_o
);
  import gbn_pkg::*;

  localparam int IdxW = $clog2(MAX_BOXES);
  localparam int CntW = $clog2(MAX_BOXES + 1);
  localparam logic [CntW-1:0] CntMax = CntW'(MAX_BOXES);
  localparam int PipeN = 5;

  // Configuration registers
  logic [15:0]      thr_q;
  logic [KeptW-1:0] maxdet_q;
  logic [KeptW-1:0] lim;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q    <= IouThrRst;
      maxdet_q <= MaxDetRst;
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_IOU_THR: thr_q    <= cfg_data_i;
        CFG_MAX_DET: maxdet_q <= cfg_data_i[KeptW-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the keep limit to 1..KeepCap
  always_comb begin
    if (maxdet_q == '0) begin
      lim = KeptW'(1);
    end else if (maxdet_q > KeepCap) begin
      lim = KeepCap;
    end else begin
      lim = maxdet_q;
    end
  end

  // Set counters and pass control
  logic [CntW-1:0]  cnt_q, iss_q;
  logic             ovf_q, have_pick_q, best_found_q;
  logic [KeptW-1:0] kept_q;
  logic             room, load_we;

  assign room    = cnt_q < CntMax;
  assign load_we = cmd_i.load && room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      ovf_q       <= 1'b0;
      iss_q       <= '0;
      have_pick_q <= 1'b0;
      kept_q      <= '0;
    end else begin
      if (cmd_i.clr_set) begin
        cnt_q <= '0;
        ovf_q <= 1'b0;
      end else if (cmd_i.load) begin
        if (room) cnt_q <= cnt_q + CntW'(1);
        else      ovf_q <= 1'b1;
      end
      if (cmd_i.set_start || cmd_i.pass_start) begin
        iss_q <= '0;
      end else if (cmd_i.issue) begin
        iss_q <= iss_q + CntW'(1);
      end
      if (cmd_i.set_start) begin
        have_pick_q <= 1'b0;
        kept_q      <= '0;
      end else if (cmd_i.take_pick) begin
        have_pick_q <= 1'b1;
        kept_q      <= kept_q + KeptW'(1);
      end
    end
  end

  // Pipeline valid and carried entry
  logic            v1_q;
  logic [IdxW-1:0] i1_q;
  logic [PipeN-1:0] vld_q;
  logic [IdxW-1:0] idx_q [PipeN];
  box_t            box_q [PipeN];
  logic [PipeN-1:0] rm_q;

  // Box store and removed-flag store
  box_t in_box, rd_box;
  logic rd_rm;
  logic sup_we;
  logic [IdxW-1:0] rm_waddr;

  assign in_box   = box_t'(in_data_i[BoxW-1:0]);

  gbn_ram #(.Width(BoxW), .Depth(MAX_BOXES)) u_box_ram (
    .clk_i   (clk_i),
    .we_i    (load_we),
    .waddr_i (cnt_q[IdxW-1:0]),
    .wdata_i (in_box),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (rd_box)
  );

  assign rm_waddr = load_we ? cnt_q[IdxW-1:0] : idx_q[PipeN-1];

  gbn_ram #(.Width(1), .Depth(MAX_BOXES)) u_rm_ram (
    .clk_i   (clk_i),
    .we_i    (load_we || sup_we),
    .waddr_i (rm_waddr),
    .wdata_i (~load_we),
    .raddr_i (iss_q[IdxW-1:0]),
    .rdata_o (rd_rm)
  );

  // Kept box
  box_t            pick_q, best_q;
  logic [IdxW-1:0] pick_idx_q, best_idx_q;
  logic [29:0]     area_a_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.take_pick) begin
      pick_q     <= best_q;
      pick_idx_q <= best_idx_q;
      area_a_q   <= best_q.width * best_q.height;
    end
  end

  // Advance the pipeline valid bits and carried entry
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      vld_q <= '0;
    end else begin
      v1_q  <= cmd_i.issue;
      vld_q <= {vld_q[PipeN-2:0], v1_q};
    end
  end

  always_ff @(posedge clk_i) begin
    i1_q     <= iss_q[IdxW-1:0];
    idx_q[0] <= i1_q;
    box_q[0] <= rd_box;
    rm_q[0]  <= rd_rm;
    for (int k = 1; k < PipeN; k++) begin
      idx_q[k] <= idx_q[k-1];
      box_q[k] <= box_q[k-1];
      rm_q[k]  <= rm_q[k-1];
    end
  end

  // Overlap corners and candidate area
  logic signed [16:0] a_l, a_r, a_t, a_b, b_l, b_r, b_t, b_b;
  logic signed [16:0] x1_d, x2_d, y1_d, y2_d;
  logic signed [16:0] x1_q, x2_q, y1_q, y2_q;
  logic [29:0]        area_b_d, area_b2_q, area_b3_q, area_b4_q;

  always_comb begin
    a_l  = 17'($signed(pick_q.left));
    a_t  = 17'($signed(pick_q.top));
    b_l  = 17'($signed(rd_box.left));
    b_t  = 17'($signed(rd_box.top));
    a_r  = a_l + $signed({2'b00, pick_q.width});
    a_b  = a_t + $signed({2'b00, pick_q.height});
    b_r  = b_l + $signed({2'b00, rd_box.width});
    b_b  = b_t + $signed({2'b00, rd_box.height});
    x1_d = (a_l > b_l) ? a_l : b_l;
    y1_d = (a_t > b_t) ? a_t : b_t;
    x2_d = (a_r < b_r) ? a_r : b_r;
    y2_d = (a_b < b_b) ? a_b : b_b;
    area_b_d = rd_box.width * rd_box.height;
  end

  // Clamped overlap extents
  logic signed [17:0] dxs, dys;
  logic [14:0]        dx_d, dy_d, dx_q, dy_q;

  always_comb begin
    dxs  = 18'(x2_q) - 18'(x1_q);
    dys  = 18'(y2_q) - 18'(y1_q);
    dx_d = (dxs > 0) ? dxs[14:0] : '0;
    dy_d = (dys > 0) ? dys[14:0] : '0;
  end

  // Intersection, union and threshold product
  logic [29:0] inter3_q, inter4_q, inter5_q;
  logic [30:0] uni_d, uni_q;
  logic [46:0] prod_q;
  logic        unz_q;

  assign uni_d = 31'(area_a_q) + 31'(area_b4_q) - 31'(inter3_q);

  always_ff @(posedge clk_i) begin
    x1_q      <= x1_d;
    x2_q      <= x2_d;
    y1_q      <= y1_d;
    y2_q      <= y2_d;
    area_b2_q <= area_b_d;
    dx_q      <= dx_d;
    dy_q      <= dy_d;
    area_b3_q <= area_b2_q;
    area_b4_q <= area_b3_q;
    inter3_q  <= dx_q * dy_q;
    inter4_q  <= inter3_q;
    uni_q     <= uni_d;
    inter5_q  <= inter4_q;
    prod_q    <= thr_q * uni_q;
    unz_q     <= uni_q != '0;
  end

  // Suppress or track the best survivor
  logic ovl, self_hit, live, surv;

  always_comb begin
    ovl      = have_pick_q && unz_q && ({1'b0, inter5_q, 16'h0000} > prod_q);
    self_hit = have_pick_q && (idx_q[PipeN-1] == pick_idx_q);
    live     = vld_q[PipeN-1] && !rm_q[PipeN-1];
    sup_we   = live && (self_hit || ovl);
    surv     = live && !self_hit && !ovl;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      best_found_q <= 1'b0;
    end else if (cmd_i.set_start || cmd_i.pass_start) begin
      best_found_q <= 1'b0;
    end else if (surv) begin
      best_found_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (surv && (!best_found_q || (box_q[PipeN-1].score > best_q.score))) begin
      best_q     <= box_q[PipeN-1];
      best_idx_q <= idx_q[PipeN-1];
    end
  end

  // Output register
  logic                out_valid_q, out_last_q;
  logic [OutDataW-1:0] out_data_q;
  logic [OutUserW-1:0] out_user_q;
  logic [KeptIdxW-1:0] kidx;

  assign kidx = KeptIdxW'(pick_idx_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_tready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_last_q <= cmd_i.emit_last || cmd_i.emit_none;
      out_user_q <= {ovf_q, !cmd_i.emit_none};
      out_data_q <= cmd_i.emit_none ? '0 : {4'b0000, pick_q, kidx};
    end
  end

  assign out_tvalid_o = out_valid_q;
  assign out_tdata_o  = out_data_q;
  assign out_tuser_o  = out_user_q;
  assign out_tlast_o  = out_last_q;

  // Status
  always_comb begin
    sts_o.issue_avail = iss_q < cnt_q;
    sts_o.pipe_empty  = !v1_q && (vld_q == '0);
    sts_o.best_found  = best_found_q;
    sts_o.have_pick   = have_pick_q;
    sts_o.at_limit    = (kept_q + KeptW'(1)) >= lim;
    sts_o.out_busy    = out_valid_q;
  end

endmodule

// File: hw/rtl/greedy_box_nms.sv
// Greedy box suppression: boxes load at one per cycle, but only in the load state;
// selection starts after the last box, and no input is accepted during selection.
// Each selection pass streams all N stored boxes through the IoU pipeline; the first
// pass finds the top box, each kept box costs one more pass, and the output register
// holds one result. Reset clears counts, flags, output valid and restores the two config
// registers; box stores need no clearing, as each entry is written before it is read.
`include "assert_macros.svh"

module greedy_box_nms #(
  parameter int MAX_BOXES = gbn_pkg::MaxBoxesDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // tdata: box_left[15:0], box_top[31:16], box_width[46:32], box_height[61:47],
  //        box_score[77:62], zero pad[79:78]
  input  logic                          s_axis_tvalid,
  output logic                          s_axis_tready,
  input  logic [gbn_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  // tdata: kept_index[5:0], kept_left[21:6], kept_top[37:22], kept_width[52:38],
  //        kept_height[67:53], kept_score[83:68], zero pad[87:84]
  output logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  output logic [gbn_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: kept_valid[0], overflow_seen[1]
  output logic [gbn_pkg::OutUserW-1:0]  m_axis_tuser,
  output logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  output logic                          cfg_ready_o,
  input  logic [gbn_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gbn_pkg::CfgDataW-1:0]  cfg_data_i
);
  import gbn_pkg::*;

  gbn_cmd_t cmd;
  gbn_sts_t sts;

  assign cfg_ready_o = 1'b1;

  gbn_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_tvalid_i (s_axis_tvalid),
    .in_tlast_i  (s_axis_tlast),
    .in_tready_o (s_axis_tready),
    .sts_i       (sts),
    .cmd_o       (cmd)
  );

  gbn_datapath #(.MAX_BOXES(MAX_BOXES)) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .in_data_i    (s_axis_tdata),
    .cfg_valid_i  (cfg_valid_i),
    .cfg_index_i  (cfg_index_i),
    .cfg_data_i   (cfg_data_i),
    .out_tvalid_o (m_axis_tvalid),
    .out_tready_i (m_axis_tready),
    .out_tdata_o  (m_axis_tdata),
    .out_tuser_o  (m_axis_tuser),
    .out_tlast_o  (m_axis_tlast)
  );

  // No box is read for a pass while boxes are still being loaded
  `GBN_ASSERT(a_no_issue_in_load, !(s_axis_tready && cmd.issue), "scan issued during load")
  // A result is only loaded into a free output register
  `GBN_ASSERT_IMPL(a_emit_when_free, cmd.emit, !sts.out_busy, "emit over pending result")
  // A box is only kept when the pass found a survivor
  `GBN_ASSERT_IMPL(a_pick_has_best, cmd.take_pick, sts.best_found, "keep without survivor")

endmodule

// File: tb/greedy_box_nms_checker.sv
// Checker for greedy_box_nms: predicts kept boxes per set and compares the output stream.
`timescale 1ns / 100ps

module greedy_box_nms_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          s_axis_tvalid,
  input  logic                          s_axis_tready,
  // tdata: left, top, width, height, score from the lowest bit up
  input  logic [gbn_pkg::InDataW-1:0]   s_axis_tdata,
  input  logic                          s_axis_tlast,
  input  logic                          m_axis_tvalid,
  input  logic                          m_axis_tready,
  // tdata: index, left, top, width, height, score from the lowest bit up
  input  logic [gbn_pkg::OutDataW-1:0]  m_axis_tdata,
  // tuser: kept_valid, overflow_seen from the lowest bit up
  input  logic [gbn_pkg::OutUserW-1:0]  m_axis_tuser,
  input  logic                          m_axis_tlast,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_o,
  input  logic [gbn_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [gbn_pkg::CfgDataW-1:0]  cfg_data_i,
  output int                            errors_o,
  output int                            pending_o
);
  import gbn_pkg::*;

  typedef struct packed {
    logic        valid;
    logic [5:0]  index;
    box_t        box;
    logic        overflow;
    logic        last;
  } kept_t;

  box_t        held_boxes[64];
  int          held_count;
  logic        dropped;
  logic [15:0] iou_thr;
  logic [6:0]  max_det;
  kept_t       kept_q[$];

  task automatic report(input string what, input int got, input int want);
    $display("[%0t] mismatch %s: got %0d want %0d", $time, what, got, want);
    errors_o++;
  endtask

  // True when the lower-ranked box b is suppressed by kept box a
  function automatic bit suppresses(input box_t a, input box_t b);
    longint la, ta, lb, tb, wa, ha, wb, hb, x1, y1, x2, y2, dx, dy, inter, uni;
    la = $signed(a.left); ta = $signed(a.top); wa = a.width; ha = a.height;
    lb = $signed(b.left); tb = $signed(b.top); wb = b.width; hb = b.height;
    x1 = (la > lb) ? la : lb;
    y1 = (ta > tb) ? ta : tb;
    x2 = (la + wa < lb + wb) ? la + wa : lb + wb;
    y2 = (ta + ha < tb + hb) ? ta + ha : tb + hb;
    dx = (x2 > x1) ? x2 - x1 : 0;
    dy = (y2 > y1) ? y2 - y1 : 0;
    inter = dx * dy;
    uni = wa * ha + wb * hb - inter;
    if (uni <= 0) return 0;
    return inter * 65536 > longint'(iou_thr) * uni;
  endfunction

  // Rank the set, walk it greedily and queue the kept boxes
  task automatic select_set();
    int   rank[64];
    bit   supp[64];
    int   limit, kept, i, j;
    kept_t k;
    limit = (max_det < 1) ? 1 : (max_det > 64) ? 64 : max_det;
    kept = 0;
    for (i = 0; i < held_count; i++) begin
      supp[i] = 0;
      j = i;
      while (j > 0 && held_boxes[rank[j-1]].score < held_boxes[i].score) begin
        rank[j] = rank[j-1];
        j--;
      end
      rank[j] = i;
    end
    for (i = 0; i < held_count && kept < limit; i++) begin
      if (supp[i]) continue;
      k.valid = 1;
      k.index = rank[i][5:0];
      k.box = held_boxes[rank[i]];
      k.overflow = dropped;
      k.last = 0;
      kept_q = {kept_q, k};
      kept++;
      if (kept >= limit) break;
      for (j = i + 1; j < held_count; j++)
        if (!supp[j] && suppresses(held_boxes[rank[i]], held_boxes[rank[j]])) supp[j] = 1;
    end
    if (kept == 0) begin
      k = '0;
      k.overflow = dropped;
      k.last = 1;
      kept_q = {kept_q, k};
    end else begin
      kept_q[kept_q.size()-1].last = 1;
    end
    held_count = 0;
    dropped = 0;
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    kept_t want;
    box_t  got_box;
    if (!rst_ni) begin
      held_count = 0;
      dropped = 0;
      iou_thr = IouThrRst;
      max_det = MaxDetRst;
      errors_o = 0;
      pending_o = 0;
      kept_q.delete();
    end else begin
      // Track register writes
      if (cfg_valid_i && cfg_ready_o) begin
        if (cfg_index_i == CFG_IOU_THR) iou_thr = cfg_data_i;
        else if (cfg_index_i == CFG_MAX_DET) max_det = cfg_data_i[6:0];
      end
      // Compare an output transaction with the oldest expectation
      if (m_axis_tvalid && m_axis_tready) begin
        if (kept_q.size() == 0) begin
          report("unexpected result transaction", 1, 0);
        end else begin
          want = kept_q.pop_front();
          got_box = '0;
          got_box.left = m_axis_tdata[21:6];
          got_box.top = m_axis_tdata[37:22];
          got_box.width = m_axis_tdata[52:38];
          got_box.height = m_axis_tdata[67:53];
          got_box.score = m_axis_tdata[83:68];
          if (m_axis_tuser[0] !== want.valid) report("kept_valid", m_axis_tuser[0], want.valid);
          if (m_axis_tdata[5:0] !== want.index)
            report("kept_index", m_axis_tdata[5:0], want.index);
          if (got_box.left !== want.box.left)
            report("kept_left", $signed(got_box.left), $signed(want.box.left));
          if (got_box.top !== want.box.top)
            report("kept_top", $signed(got_box.top), $signed(want.box.top));
          if (got_box.width !== want.box.width)
            report("kept_width", got_box.width, want.box.width);
          if (got_box.height !== want.box.height)
            report("kept_height", got_box.height, want.box.height);
          if (got_box.score !== want.box.score)
            report("kept_score", got_box.score, want.box.score);
          if (m_axis_tuser[1] !== want.overflow)
            report("overflow_seen", m_axis_tuser[1], want.overflow);
          if (m_axis_tlast !== want.last) report("last_result", m_axis_tlast, want.last);
        end
      end
      // Store an input transaction and select on the last box
      if (s_axis_tvalid && s_axis_tready) begin
        if (held_count < 64) begin
          held_boxes[held_count] = s_axis_tdata[BoxW-1:0];
          held_count++;
        end else begin
          dropped = 1;
        end
        if (s_axis_tlast) select_set();
      end
      pending_o = kept_q.size();
    end
  end

endmodule

// File: tb/greedy_box_nms_tb.sv
// Top of the greedy_box_nms testbench: clock, reset, stimulus and verdict.
`timescale 1ns / 100ps

module greedy_box_nms_tb;
  import gbn_pkg::*;

  localparam int DrainCycles = 40;

  logic                  clk_i = 0;
  logic                  rst_ni = 0;
  logic                  s_axis_tvalid = 0;
  logic                  s_axis_tready;
  logic [InDataW-1:0]    s_axis_tdata = '0;
  logic                  s_axis_tlast = 0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 0;
  logic [OutDataW-1:0]   m_axis_tdata;
  logic [OutUserW-1:0]   m_axis_tuser;
  logic                  m_axis_tlast;
  logic                  cfg_valid_i = 0;
  logic                  cfg_ready_o;
  logic [CfgIdxW-1:0]    cfg_index_i = CFG_IOU_THR;
  logic [CfgDataW-1:0]   cfg_data_i = '0;
  int                    errors;
  int                    pending;
  bit                    quiet = 0;
  int                    stall_left = 0;

  always #5 clk_i = ~clk_i;

  greedy_box_nms uut (.*);

  greedy_box_nms_checker chk (.*, .errors_o(errors), .pending_o(pending));

  // Stall the result side in random bursts
  always @(negedge clk_i) begin
    if (quiet) begin
      m_axis_tready <= 1;
    end else if (stall_left > 0) begin
      m_axis_tready <= 0;
      stall_left <= stall_left - 1;
    end else if ($urandom_range(0, 4) == 0) begin
      m_axis_tready <= 0;
      stall_left <= $urandom_range(0, 5);
    end else begin
      m_axis_tready <= 1;
    end
  end

  // Send one box transaction, with an occasional idle burst first
  task automatic send_box(input box_t b, input bit last);
    if (!quiet && $urandom_range(0, 3) == 0) begin
      s_axis_tvalid <= 0;
      repeat ($urandom_range(1, 6)) @(negedge clk_i);
    end
    s_axis_tdata <= {{(InDataW-BoxW){1'b0}}, b};
    s_axis_tlast <= last;
    s_axis_tvalid <= 1;
    do @(posedge clk_i); while (!s_axis_tready);
    @(negedge clk_i);
  endtask

  // Hold until the block has drained, then idle a while
  task automatic drain();
    s_axis_tvalid <= 0;
    while (pending != 0) @(negedge clk_i);
    repeat (DrainCycles) @(negedge clk_i);
  endtask

  task automatic write_reg(input cfg_idx_e idx, input logic [15:0] val);
    drain();
    cfg_index_i <= idx;
    cfg_data_i <= val;
    cfg_valid_i <= 1;
    do @(posedge clk_i); while (!cfg_ready_o);
    @(negedge clk_i);
    cfg_valid_i <= 0;
  endtask

  function automatic box_t make_box(input box_t anchor, input bit wild);
    box_t b;
    if (wild) begin
      b = BoxW'({$urandom, $urandom, $urandom});
    end else begin
      b.left = anchor.left + 16'($signed($urandom_range(0, 160)) - 80);
      b.top = anchor.top + 16'($signed($urandom_range(0, 160)) - 80);
      b.width = anchor.width + 15'($urandom_range(0, 64));
      b.height = anchor.height + 15'($urandom_range(0, 64));
      b.score = ($urandom_range(0, 3) == 0) ? anchor.score : 16'($urandom);
    end
    return b;
  endfunction

  // One set of boxes: mostly clustered so that suppression happens
  task automatic send_set(input int n);
    box_t anchor, b;
    int i;
    anchor = BoxW'({$urandom, $urandom, $urandom});
    anchor.width = 15'($urandom_range(0, 600));
    anchor.height = 15'($urandom_range(0, 600));
    for (i = 0; i < n; i++) begin
      if ($urandom_range(0, 3) == 0)
        anchor = make_box(anchor, 1);
      b = make_box(anchor, $urandom_range(0, 5) == 0);
      send_box(b, i == n - 1);
    end
  endtask

  task automatic random_sets(input int items);
    int n;
    while (items > 0) begin
      n = $urandom_range(1, 10);
      send_set(n);
      items -= n;
    end
  endtask

  initial begin
    box_t b;
    repeat (3) @(negedge clk_i);
    rst_ni <= 1;
    @(negedge clk_i);

    // Single box at field extremes
    b = '0;
    b.left = 16'sh8000; b.top = 16'sh7fff; b.width = 15'h7fff; b.height = 15'd0;
    b.score = 16'd0;
    send_box(b, 1);
    b.left = 16'sh7fff; b.top = 16'sh8000; b.width = 15'd0; b.height = 15'h7fff;
    b.score = 16'hffff;
    send_box(b, 1);
    // Equal scores on identical boxes, zero-area pair, disjoint box
    b = '0; b.left = 16'sd100; b.top = 16'sd100; b.width = 15'd50; b.height = 15'd50;
    b.score = 16'd1000;
    send_box(b, 0);
    send_box(b, 0);
    b.width = 15'd0; b.height = 15'd0; b.score = 16'd900;
    send_box(b, 0);
    send_box(b, 0);
    b.left = -16'sd5000; b.width = 15'd20; b.height = 15'd20; b.score = 16'd1000;
    send_box(b, 1);

    write_reg(CFG_IOU_THR, 16'd0);
    write_reg(CFG_MAX_DET, 16'd0);
    random_sets(35);
    write_reg(CFG_IOU_THR, 16'hffff);
    write_reg(CFG_MAX_DET, 16'd127);
    random_sets(35);
    // Overfull set: the store fills and later boxes are dropped
    send_set(70);
    write_reg(CFG_IOU_THR, 16'd16384);
    write_reg(CFG_MAX_DET, 16'd1);
    random_sets(25);
    write_reg(CFG_MAX_DET, 16'd64);
    send_set(64);
    drain();
    write_reg(CFG_IOU_THR, 16'd29491);
    write_reg(CFG_MAX_DET, 16'd3);
    random_sets(25);
    quiet = 1;
    write_reg(CFG_MAX_DET, 16'd64);
    random_sets(35);

    drain();
    if (errors == 0) $display("greedy_box_nms regression: pass");
    else $display("greedy_box_nms regression: fail");
    $finish;
  end

  initial begin
    #5ms;
    $display("greedy_box_nms regression: fail");
    $finish;
  end

endmodule
